/* hdl/gaa_pkg.sv */
package gaa_pkg;

	// Storage geometry.
	localparam int MAX_ENTRIES = 1024;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int SUM_W       = 48;
	localparam int GRAD_W      = 32;
	localparam int CNT_W       = 16;
	localparam int LEN_W       = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int DIV_CNT_W   = $clog2(SUM_W);

	// Item kinds.
	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_BATCH = 2'd1;

	// Request to the shared divider.
	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	// Response from the shared divider.
	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* hdl/gaa_req_if.sv */
interface gaa_req_if
	import gaa_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [1:0]               kind;
	logic [ADDR_W-1:0]        entry_index;
	logic signed [GRAD_W-1:0] gradient_value;
	logic                     batch_end;

	modport source (output valid, kind, entry_index, gradient_value, batch_end, input ready);
	modport sink (input valid, kind, entry_index, gradient_value, batch_end, output ready);
endinterface

/* hdl/gaa_rsp_if.sv */
interface gaa_rsp_if
	import gaa_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [GRAD_W-1:0] average_value;
	logic                     batch_complete;
	logic [CNT_W-1:0]         steps_done;

	modport source (output valid, average_value, batch_complete, steps_done, input ready);
	modport sink (input valid, average_value, batch_complete, steps_done, output ready);
endinterface

/* hdl/gaa_cfg_if.sv */
interface gaa_cfg_if
	import gaa_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/gaa_div.sv */
module gaa_div
	import gaa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     dvs_q;
	logic [CNT_W+1:0]     diff;
	logic                 ge;

	// One restoring step: bring down the next dividend bit and try a subtract.
	assign diff = {1'b0, rem_q, quo_q[SUM_W-1]} - {2'b00, dvs_q};
	assign ge   = ~diff[CNT_W+1];

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient and remainder datapath; the dividend shifts out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : {rem_q[CNT_W-2:0], quo_q[SUM_W-1]};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* hdl/gradient_accumulator_average_core.sv */
// Flow: an add or a read passes the READ state, where an in-range add writes back the sum
// and an in-range read starts the 48-step shared divider (DIV); a clear runs the zeroing
// sweep (CLR); every item then waits in FIN until the output register is free.
// Items are taken one at a time; the next is accepted only after FIN hands the last one on.
// Reset: asynchronous, active low; afterwards a zeroing pass sweeps the sum memory, one entry
// per cycle, before the first item is accepted.
module gradient_accumulator_average_core
	import gaa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	gaa_req_if.sink    req,
	gaa_rsp_if.source  rsp,
	gaa_cfg_if.sink    cfg
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_CLR  = 3'd4;

	logic [2:0]               state_q;
	logic [LEN_W-1:0]         vec_len_q;
	logic [CNT_W-1:0]         spb_q;
	logic [CNT_W-1:0]         step_cnt_q;
	logic [ADDR_W-1:0]        clr_addr_q;
	logic                     clr_item_q;
	logic [1:0]               kind_q;
	logic [ADDR_W-1:0]        idx_q;
	logic signed [GRAD_W-1:0] grad_q;
	logic                     last_q;
	logic                     ok_q;
	logic                     neg_q;
	logic signed [GRAD_W-1:0] res_avg_q;
	logic                     out_valid_q;
	logic signed [GRAD_W-1:0] out_avg_q;
	logic                     out_cmp_q;
	logic [CNT_W-1:0]         out_cnt_q;

	logic [SUM_W-1:0]         mem [MAX_ENTRIES];
	logic [SUM_W-1:0]         rd_data_q;

	logic                     accept;
	logic                     index_ok;
	logic [CNT_W-1:0]         divisor;
	logic [SUM_W:0]           sum_wide;
	logic [SUM_W-1:0]         sum_sat;
	logic                     wr_en;
	logic [ADDR_W-1:0]        wr_addr;
	logic [SUM_W-1:0]         wr_data;
	logic                     fin_load;
	logic [GRAD_W-1:0]        avg_sat;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign index_ok = {1'b0, req.entry_index} < vec_len_q;
	assign divisor  = (spb_q == '0) ? CNT_W'(1) : spb_q;
	assign fin_load = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_len_q <= LEN_W'(MAX_ENTRIES);
			spb_q     <= CNT_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_VECTOR_LENGTH:   vec_len_q <= cfg.data[LEN_W-1:0];
				REG_STEPS_PER_BATCH: spb_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	// Saturating 48-bit accumulate of the stored sum and the gradient.
	always_comb begin
		sum_wide = {rd_data_q[SUM_W-1], rd_data_q} + {{(SUM_W-GRAD_W+1){grad_q[GRAD_W-1]}}, grad_q};
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	// Memory write port: zeroing sweep or add write-back.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = sum_sat;
		if (state_q == ST_CLR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else if (state_q == ST_READ && kind_q == KIND_ADD && ok_q) begin
			wr_en = 1'b1;
		end
	end

	// Sum memory with registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (accept) begin
			rd_data_q <= mem[req.entry_index];
		end
	end

	// Divider request: magnitude of the sum over the effective divisor.
	always_comb begin
		div_req.start    = (state_q == ST_READ) && (kind_q == KIND_READ) && ok_q;
		div_req.dividend = rd_data_q[SUM_W-1] ? (~rd_data_q + 1'b1) : rd_data_q;
		div_req.divisor  = divisor;
	end

	gaa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Signed quotient saturated to 32 bits.
	always_comb begin
		if (!neg_q) begin
			avg_sat = (div_rsp.quotient > SUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
				: div_rsp.quotient[GRAD_W-1:0];
		end else begin
			avg_sat = (div_rsp.quotient > SUM_W'(32'h8000_0000)) ? 32'h8000_0000
				: (~div_rsp.quotient[GRAD_W-1:0] + 1'b1);
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_addr_q <= '0;
			clr_item_q <= 1'b0;
			step_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.kind == KIND_CLEAR) begin
							state_q    <= ST_CLR;
							clr_addr_q <= '0;
							clr_item_q <= 1'b1;
							step_cnt_q <= '0;
						end else if (req.kind == KIND_ADD || req.kind == KIND_READ) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_READ: begin
					if (kind_q == KIND_ADD && last_q && step_cnt_q != '1) begin
						step_cnt_q <= step_cnt_q + 1'b1;
					end
					state_q <= div_req.start ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(MAX_ENTRIES - 1)) begin
						state_q <= clr_item_q ? ST_FIN : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item fields held for the duration of the item.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= req.kind;
			idx_q     <= req.entry_index;
			grad_q    <= req.gradient_value;
			last_q    <= req.batch_end;
			ok_q      <= index_ok;
			res_avg_q <= '0;
		end else begin
			if (div_req.start) begin
				neg_q <= rd_data_q[SUM_W-1];
			end
			if (state_q == ST_DIV && div_rsp.done) begin
				res_avg_q <= avg_sat;
			end
		end
	end

	// Output register: holds one finished item until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_avg_q <= res_avg_q;
			out_cmp_q <= step_cnt_q >= divisor;
			out_cnt_q <= step_cnt_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.average_value  = out_avg_q;
	assign rsp.batch_complete = out_cmp_q;
	assign rsp.steps_done     = out_cnt_q;

	// No item is taken during the zeroing sweep.
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !req.ready)
		else $error("item accepted during zeroing sweep");

	// The divider only finishes while the sequencer waits for it.
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");

	// The micro-batch counter changes only in IDLE (cleared) and READ (stepped by one): elsewhere it holds or is zero.
	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_READ) |=> $stable(step_cnt_q) || step_cnt_q == '0)
		else $error("micro-batch counter changed outside an add");

	// A result is never overwritten before it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> out_valid_q && $stable(out_cnt_q))
		else $error("pending result lost");

endmodule
